@@ sv/ole_pkg.sv @@
// Shared constants, codes and types of the ordered list engine.
package ole_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_APPEND_BACK = 3'd1,
    CMD_SORTED_INS  = 3'd2,
    CMD_REMOVE_HEAD = 3'd3,
    CMD_REMOVE_VAL  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } ctl_t;

  // registered result
  typedef struct packed {
    status_e status;
    value_t  head_value;
    logic    list_nonempty;
    count_t  entry_count;
  } result_t;

endpackage

@@ sv/ole_if.sv @@
// Valid/ready channel interfaces for commands and results.
interface ole_in_if;
  logic                              valid;
  logic                              ready;
  logic [ole_pkg::CMD_W-1:0]         command;
  logic signed [ole_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface ole_out_if;
  logic                               valid;
  logic                               ready;
  logic [ole_pkg::STATUS_W-1:0]       status;
  logic signed [ole_pkg::VALUE_W-1:0] head_value;
  logic                               list_nonempty;
  logic [ole_pkg::CNT_W-1:0]          entry_count;

  modport source (output valid, output status, output head_value, output list_nonempty,
                  output entry_count, input ready);
  modport sink (input valid, input status, input head_value, input list_nonempty,
                input entry_count, output ready);
endinterface

@@ sv/ordered_list_engine_unit.sv @@
// Top level of the ordered list engine: bounded ordered list of signed values.
// One command transaction is accepted per cycle unless a result waits untaken;
// its result appears in the output register on the next cycle and stays there
// until taken, while the next command is accepted in the same cycle the result
// is taken. The figure is set by the row of 16 compare/shift cells, which locate
// the slot and move every entry in the same cycle. No clearing pass follows reset.
module ordered_list_engine_unit (
  input  logic clk_i,
  input  logic rst_ni,
  ole_in_if.sink    in_i,
  ole_out_if.source out_o
);
  import ole_pkg::*;

  ctl_t    ctl;
  result_t res;

  ole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  ole_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .command_i (in_i.command),
    .value_i   (in_i.value),
    .result_o  (res)
  );

  assign out_o.status        = res.status;
  assign out_o.head_value    = res.head_value;
  assign out_o.list_nonempty = res.list_nonempty;
  assign out_o.entry_count   = res.entry_count;

endmodule

@@ sv/ole_ctrl.sv @@
// Handshake controller: accepts a transaction and tracks the output register.
module ole_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ole_pkg::ctl_t ctl_o
);
  import ole_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic exec;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_HOLD);
  assign ctl_o.exec  = exec;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (exec) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready_i && !exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (state_q == S_HOLD))
    else $error("accepted transaction did not load a result");

  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> ((state_q == S_IDLE) || out_ready_i))
    else $error("transaction accepted over a pending result");

  a_drain_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_HOLD) && out_ready_i && !in_valid_i) |=> (state_q == S_IDLE))
    else $error("result taken but still reported valid");

endmodule

@@ sv/ole_dpath.sv @@
// Datapath: row of compare/shift cells holding the list plus result register.
module ole_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ole_pkg::ctl_t                 ctl_i,
  input  logic [ole_pkg::CMD_W-1:0]     command_i,
  input  logic signed [ole_pkg::VALUE_W-1:0] value_i,
  output ole_pkg::result_t              result_o
);
  import ole_pkg::*;

  value_t     ent_q [DEPTH];
  value_t     ent_d [DEPTH];
  value_t     prv   [DEPTH];
  value_t     nxt   [DEPTH];
  count_t     count_q, count_d;
  result_t    res_q, res_d;
  logic [DEPTH-1:0] lt, eq, keep_srt, match_incl, keep, kp, shift;
  logic       run_lt, run_eq, full, empty, ins, rem;
  status_e    status;

  always_comb begin
    run_lt = 1'b1;
    run_eq = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      lt[i]         = (CNT_W'(i) < count_q) && (ent_q[i] < value_i);
      eq[i]         = (CNT_W'(i) < count_q) && (ent_q[i] == value_i);
      run_lt        = run_lt && lt[i];
      keep_srt[i]   = run_lt;
      run_eq        = run_eq || eq[i];
      match_incl[i] = run_eq;
    end
    full  = (count_q == CNT_W'(DEPTH));
    empty = (count_q == '0);

    status = ST_OK;
    ins    = 1'b0;
    rem    = 1'b0;
    keep   = '0;
    shift  = '0;
    case (command_i)
      CMD_PUSH_FRONT, CMD_APPEND_BACK, CMD_SORTED_INS: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins = 1'b1;
          if (command_i == CMD_APPEND_BACK) begin
            for (int i = 0; i < DEPTH; i++) keep[i] = (CNT_W'(i) < count_q);
          end else if (command_i == CMD_SORTED_INS) begin
            keep = keep_srt;
          end
        end
      end
      CMD_REMOVE_HEAD: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rem   = 1'b1;
          shift = '1;
        end
      end
      CMD_REMOVE_VAL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!run_eq) begin
          status = ST_MISSING;
        end else begin
          rem   = 1'b1;
          shift = match_incl;
        end
      end
      default: ;
    endcase

    prv[0] = ent_q[0];
    kp[0]  = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      prv[i] = ent_q[i-1];
      kp[i]  = keep[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) nxt[i] = ent_q[i+1];
    nxt[DEPTH-1] = ent_q[DEPTH-1];

    for (int i = 0; i < DEPTH; i++) begin
      if (ins) begin
        if (keep[i])     ent_d[i] = ent_q[i];
        else if (kp[i])  ent_d[i] = value_i;
        else             ent_d[i] = prv[i];
      end else if (rem && shift[i]) begin
        ent_d[i] = nxt[i];
      end else begin
        ent_d[i] = ent_q[i];
      end
    end

    if (ins)      count_d = count_q + 1'b1;
    else if (rem) count_d = count_q - 1'b1;
    else          count_d = count_q;

    res_d.status        = status;
    res_d.list_nonempty = (count_d != '0);
    res_d.head_value    = (count_d != '0) ? ent_d[0] : '0;
    res_d.entry_count   = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      ent_q <= ent_d;
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_remove_head_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && (command_i == CMD_REMOVE_HEAD) && !empty)
      |=> (count_q == $past(count_q) - 1'b1))
    else $error("remove head did not shrink the list");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for ordered_list_engine_unit, with its own shadow list model.
module tb;
  import ole_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_LEN = 220;
  localparam int unsigned HOLD_AT = 500;
  localparam int unsigned HOLD_LEN = 300;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    value_t           val;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ole_in_if  cmd_if ();
  ole_out_if res_if ();

  ordered_list_engine_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  value_t      shadow_list[$];
  result_t     pending_results[$];
  dir_row_t    dir_rows[$];
  bit          row_typed;
  result_t     row_want;
  int unsigned mismatches;
  int unsigned results_seen;

  // Applies one command to the shadow list and returns the result it gives.
  function automatic result_t apply_command(logic [CMD_W-1:0] c, value_t v);
    result_t r;
    int      pos;
    r.status = ST_OK;
    case (c)
      CMD_PUSH_FRONT, CMD_APPEND_BACK, CMD_SORTED_INS: begin
        if (shadow_list.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          shadow_list.push_front(v);
        end else if (c == CMD_APPEND_BACK) begin
          shadow_list.push_back(v);
        end else begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos] < v) pos++;
          shadow_list.insert(pos, v);
        end
      end
      CMD_REMOVE_HEAD: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      CMD_REMOVE_VAL: begin
        if (shadow_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
          if (pos >= shadow_list.size()) r.status = ST_MISSING;
          else shadow_list.delete(pos);
        end
      end
      default: ;
    endcase
    r.head_value    = (shadow_list.size() > 0) ? shadow_list[0] : '0;
    r.list_nonempty = (shadow_list.size() > 0);
    r.entry_count   = count_t'(shadow_list.size());
    return r;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] c, value_t v);
    dir_row_t row;
    row.cmd   = c;
    row.val   = v;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_chk(logic [CMD_W-1:0] c, value_t v, status_e st, value_t head,
                                  int unsigned cnt);
    dir_row_t row;
    row.cmd                = c;
    row.val                = v;
    row.typed              = 1'b1;
    row.want.status        = st;
    row.want.head_value    = head;
    row.want.list_nonempty = (cnt != 0);
    row.want.entry_count   = count_t'(cnt);
    dir_rows.push_back(row);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // clustered small values collide often, which drives ordering and search
  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return value_t'(int'($urandom_range(0, 16)) - 8);
    if (r < 55) begin
      case ($urandom_range(0, 2))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        default: return '1;
      endcase
    end
    return value_t'($urandom);
  endfunction

  task automatic put_cmd(input logic [CMD_W-1:0] c, input value_t v, input bit typed,
                         input result_t want, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= c;
    cmd_if.value   <= v;
    row_typed      <= typed;
    row_want       <= want;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    cmd_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic report(string what, result_t exp_r, result_t got_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: exp st=%0d head=%0d ne=%0b cnt=%0d | got st=%0d head=%0d ne=%0b cnt=%0d",
               what, exp_r.status, exp_r.head_value, exp_r.list_nonempty, exp_r.entry_count,
               got_r.status, got_r.head_value, got_r.list_nonempty, got_r.entry_count);
    end
  endtask

  // transaction monitor: predict on command accept, check on result accept
  always @(posedge clk_i) begin
    result_t pred;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        pred = apply_command(cmd_if.command, cmd_if.value);
        pending_results.push_back(row_typed ? row_want : pred);
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        got.status        = status_e'(res_if.status);
        got.head_value    = res_if.head_value;
        got.list_nonempty = res_if.list_nonempty;
        got.entry_count   = res_if.entry_count;
        if (pending_results.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.head_value !== want.head_value ||
              got.list_nonempty !== want.list_nonempty ||
              got.entry_count !== want.entry_count) begin
            report("mismatch", want, got);
          end
        end
      end
    end
  end

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin
    int n;
    bit held;
    held = 1'b0;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      n = ((results_seen / 150) % 3 == 2) ? 0 : pick_gap();
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CMD_W-1:0] c;
    value_t           v;
    int               r;
    int               grow;
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = '0;
    cmd_if.value   = '0;
    row_typed      = 1'b0;
    row_want       = '0;
    mismatches     = 0;
    results_seen   = 0;

    add_chk(CMD_REMOVE_HEAD, '0, ST_EMPTY, '0, 0);
    add_chk(CMD_REMOVE_VAL, value_t'(5), ST_EMPTY, '0, 0);
    add_chk(CMD_RSVD_HI, '0, ST_OK, '0, 0);
    add_chk(CMD_PUSH_FRONT, VAL_MAX, ST_OK, VAL_MAX, 1);
    add_chk(CMD_PUSH_FRONT, VAL_MIN, ST_OK, VAL_MIN, 2);
    add_chk(CMD_SORTED_INS, '0, ST_OK, VAL_MIN, 3);
    add_chk(CMD_REMOVE_VAL, value_t'(12345), ST_MISSING, VAL_MIN, 3);
    add_chk(CMD_REMOVE_VAL, VAL_MIN, ST_OK, '0, 2);
    add_chk(CMD_SORTED_INS, '1, ST_OK, '1, 3);
    add_chk(CMD_APPEND_BACK, '0, ST_OK, '1, 4);
    add_chk(CMD_REMOVE_VAL, '0, ST_OK, '1, 3);
    add_chk(CMD_SORTED_INS, VAL_MIN, ST_OK, VAL_MIN, 4);
    add_chk(CMD_RSVD_LO, value_t'(7), ST_OK, VAL_MIN, 4);
    for (int k = 0; k < 12; k++) add_row(CMD_APPEND_BACK, value_t'(k * 1000 - 5000));
    add_chk(CMD_PUSH_FRONT, value_t'(1), ST_FULL, VAL_MIN, DEPTH);
    add_chk(CMD_APPEND_BACK, value_t'(1), ST_FULL, VAL_MIN, DEPTH);
    add_chk(CMD_SORTED_INS, VAL_MIN, ST_FULL, VAL_MIN, DEPTH);
    add_chk(CMD_REMOVE_HEAD, '0, ST_OK, '1, DEPTH - 1);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) put_cmd(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed,
                                  dir_rows[i].want, 1'b0);
    drain_wait();

    // even phases fill the list, odd phases drain it
    for (int ph = 0; ph < PHASES; ph++) begin
      grow = (ph % 2 == 0) ? 65 : 30;
      for (int k = 0; k < PHASE_LEN; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          c = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end else if (r < 3 + grow) begin
          case ($urandom_range(0, 3))
            0:       c = CMD_PUSH_FRONT;
            1:       c = CMD_APPEND_BACK;
            default: c = CMD_SORTED_INS;
          endcase
        end else begin
          c = $urandom_range(0, 1) ? CMD_REMOVE_HEAD : CMD_REMOVE_VAL;
        end
        if (c == CMD_REMOVE_VAL && shadow_list.size() > 0 && $urandom_range(0, 9) < 7)
          v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        else
          v = pick_value();
        put_cmd(c, v, 1'b0, '0, ph % 4 == 3);
      end
      if (ph == 3) drain_wait();
    end

    drain_wait();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
